// ===== sv/gss_pkg.sv =====
package gss_pkg;

  // Field element of GF(2^8) and the reduction polynomial x^8+x^4+x^3+x+1.
  typedef logic [7:0] gf_t;

  localparam logic [8:0] GF_POLY      = 9'h11B;
  localparam gf_t        GF_GENERATOR = 8'h03;
  localparam int         GROUP_ORDER  = 255;

  // Codes of the item kind field.
  localparam logic KIND_SPLIT   = 1'b0;
  localparam logic KIND_RECOVER = 1'b1;

  typedef gf_t inv_table_t [256];

  // Shift-and-add multiply with reduction after each shift.
  function automatic gf_t gf_mul(gf_t a, gf_t b);
    gf_t acc;
    gf_t x;
    acc = '0;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY[7:0] : 8'h00);
    end
    return acc;
  endfunction

  // Inverse table built from the powers of the generator: the inverse of
  // g^k is g^(order-k). Zero maps to zero.
  function automatic inv_table_t gen_inv_table();
    inv_table_t tab;
    gf_t        pw [GROUP_ORDER];
    gf_t        p;
    p = 8'h01;
    for (int k = 0; k < GROUP_ORDER; k++) begin
      pw[k] = p;
      p     = gf_mul(p, GF_GENERATOR);
    end
    tab[0] = 8'h00;
    for (int k = 0; k < GROUP_ORDER; k++) begin
      tab[pw[k]] = pw[(k == 0) ? 0 : (GROUP_ORDER - k)];
    end
    return tab;
  endfunction

  localparam inv_table_t INV_TABLE = gen_inv_table();

  // Stage one result: split answer done, recover operands prepared.
  typedef struct packed {
    logic kind;
    logic err;
    gf_t  split_y;
    gf_t  x1;
    gf_t  y1;
    gf_t  num;
    gf_t  inv;
  } prep_t;

  // Stage two result: recover slope formed.
  typedef struct packed {
    logic kind;
    logic err;
    gf_t  split_y;
    gf_t  x1;
    gf_t  y1;
    gf_t  slope;
  } slope_t;

endpackage

// ===== sv/gss_ifs.sv =====
interface gss_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] slope_a;
  logic [7:0] secret_b;
  logic [7:0] x_first;
  logic [7:0] y_first;
  logic [7:0] x_second;
  logic [7:0] y_second;

  modport source (
    output valid, kind, slope_a, secret_b, x_first, y_first, x_second, y_second,
    input  ready
  );
  modport sink (
    input  valid, kind, slope_a, secret_b, x_first, y_first, x_second, y_second,
    output ready
  );
endinterface

interface gss_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic       error;

  modport source (output valid, result_byte, error, input ready);
  modport sink (input valid, result_byte, error, output ready);
endinterface

// ===== sv/gss_prep.sv =====
module gss_prep (
  input  logic           clk,
  input  logic           rst,
  gss_req_if.sink        req,
  output logic           valid,
  output gss_pkg::prep_t data,
  input  logic           ready
);

  gss_pkg::prep_t data_next;
  gss_pkg::gf_t   dx;

  assign req.ready = !valid || ready;

  always_comb begin
    dx                = req.x_first ^ req.x_second;
    data_next.kind    = req.kind;
    data_next.err     = (req.kind == gss_pkg::KIND_RECOVER) && (dx == 8'h00);
    data_next.split_y = gss_pkg::gf_mul(req.slope_a, req.x_first) ^ req.secret_b;
    data_next.x1      = req.x_first;
    data_next.y1      = req.y_first;
    data_next.num     = req.y_first ^ req.y_second;
    data_next.inv     = gss_pkg::INV_TABLE[dx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== sv/gss_slope.sv =====
module gss_slope (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  gss_pkg::prep_t  in_data,
  output logic            in_ready,
  output logic            valid,
  output gss_pkg::slope_t data,
  input  logic            ready
);

  gss_pkg::slope_t data_next;

  assign in_ready = !valid || ready;

  always_comb begin
    data_next.kind    = in_data.kind;
    data_next.err     = in_data.err;
    data_next.split_y = in_data.split_y;
    data_next.x1      = in_data.x1;
    data_next.y1      = in_data.y1;
    data_next.slope   = gss_pkg::gf_mul(in_data.num, in_data.inv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== sv/gss_finish.sv =====
module gss_finish (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  gss_pkg::slope_t in_data,
  output logic            in_ready,
  gss_rsp_if.source       rsp
);

  logic         valid;
  gss_pkg::gf_t result_byte;
  logic         error;
  gss_pkg::gf_t result_byte_next;

  assign in_ready = !valid || rsp.ready;

  // Split gives split_y, equal-x recover 0, else intercept y1-slope*x1.
  always_comb begin
    if (in_data.kind == gss_pkg::KIND_SPLIT) begin
      result_byte_next = in_data.split_y;
    end else if (in_data.err) begin
      result_byte_next = 8'h00;
    end else begin
      result_byte_next = in_data.y1 ^ gss_pkg::gf_mul(in_data.slope, in_data.x1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result_byte <= result_byte_next;
      error       <= in_data.err;
    end
  end

  assign rsp.valid       = valid;
  assign rsp.result_byte = result_byte;
  assign rsp.error       = error;

endmodule

// ===== sv/gf256_secret_share_unit_core.sv =====
// A request passes the prep, slope and finish stage registers in turn.
// Throughput: one transaction per cycle, sustained, when the sink keeps up.
// Each stage holds one item and the ready chain lets stages fill bubbles.
// Reset (rst, synchronous, active high) empties all three stages; the block
// holds no other state.
module gf256_secret_share_unit_core (
  input  logic      clk,
  input  logic      rst,
  gss_req_if.sink   req,
  gss_rsp_if.source rsp
);

  // Stage one evaluates the split answer a*x + b with one field multiply,
  // and for recover forms dy = y1 ^ y2 and looks up the inverse of
  // dx = x1 ^ x2 in a constant table. An equal-x pair is flagged here.
  logic            prep_valid;
  logic            prep_ready;
  gss_pkg::prep_t  prep_data;

  // Stage two multiplies dy by the inverse to give the slope.
  logic            slope_valid;
  logic            slope_ready;
  gss_pkg::slope_t slope_data;

  gss_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .valid (prep_valid),
    .data  (prep_data),
    .ready (prep_ready)
  );

  gss_slope u_slope (
    .clk      (clk),
    .rst      (rst),
    .in_valid (prep_valid),
    .in_data  (prep_data),
    .in_ready (prep_ready),
    .valid    (slope_valid),
    .data     (slope_data),
    .ready    (slope_ready)
  );

  // Stage three forms the intercept y1 ^ slope*x1, picks the answer by kind
  // and holds it in the output register until the sink takes it.
  gss_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .in_valid (slope_valid),
    .in_data  (slope_data),
    .in_ready (slope_ready),
    .rsp      (rsp)
  );

endmodule

// ===== sv/gss_checker.sv =====
module gss_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] result_byte,
  input logic       error
);

  logic [2:0] in_flight;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 3'd0;
    end else begin
      in_flight <= in_flight + {2'b00, req_valid && req_ready}
                             - {2'b00, rsp_valid && rsp_ready};
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_byte) && $stable(error))
    else $error("response changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error |-> result_byte == 8'h00)
    else $error("error response with nonzero result");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 3'd3)
    else $error("more transactions in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> in_flight != 3'd0)
    else $error("response without a pending request");

endmodule

bind gf256_secret_share_unit_core gss_checker u_gss_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .result_byte (rsp.result_byte),
  .error       (rsp.error)
);
